// ===== sv/rhcm_pkg.sv =====
// Shared constants, types and arithmetic helpers for the relative HSV colour map.
package rhcm_pkg;

    localparam int CHAN_W    = 8;
    localparam int FRAC_W    = 16;
    localparam int DIV_STEPS = 16;

    localparam logic [15:0] ONE  = 16'hFFFF;
    localparam logic [15:0] HALF = 16'h7FFF;

    typedef enum logic [2:0] {
        REG_SOURCE_HUE = 3'd0,
        REG_SOURCE_SAT = 3'd1,
        REG_SOURCE_VAL = 3'd2,
        REG_TARGET_HUE = 3'd3,
        REG_TARGET_SAT = 3'd4,
        REG_TARGET_VAL = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_PASS  = 2'd0,
        MODE_HEAD  = 2'd1,
        MODE_SCALE = 2'd2,
        MODE_SAT   = 2'd3
    } remap_mode_t;

    typedef struct packed {
        logic [31:0] num;
        logic [15:0] den;
        logic [15:0] x;
        remap_mode_t mode;
    } remap_t;

    // One restoring step: acc holds {remainder, dividend bits / quotient bits}.
    function automatic logic [31:0] div_step(input logic [31:0] acc, input logic [15:0] d);
        logic [16:0] top;
        logic [16:0] diff;
        logic [31:0] res;
        top  = acc[31:15];
        diff = top - {1'b0, d};
        if (top >= {1'b0, d})
            res = {diff[15:0], acc[14:0], 1'b1};
        else
            res = {acc[30:0], 1'b0};
        return res;
    endfunction

    // x / 65535 for x below 2^32 - 65536: x = q0*65535 + (low + q0).
    function automatic logic [15:0] div65535(input logic [31:0] x);
        logic [16:0] r;
        logic [15:0] q;
        r = {1'b0, x[15:0]} + {1'b0, x[31:16]};
        if (r >= 17'd131070)
            q = x[31:16] + 16'd2;
        else if (r >= 17'd65535)
            q = x[31:16] + 16'd1;
        else
            q = x[31:16];
        return q;
    endfunction

    function automatic remap_t remap_setup(input logic [15:0] x, input logic [15:0] src,
                                           input logic [15:0] tgt);
        remap_t r;
        r.x    = x;
        r.num  = 32'd0;
        r.den  = src;
        r.mode = MODE_PASS;
        if (src != 16'd0) begin
            if (tgt > src && x > src) begin
                r.num  = (ONE - x) * (ONE - tgt) + {16'd0, (ONE - src) >> 1};
                r.den  = ONE - src;
                r.mode = MODE_HEAD;
            end
            else begin
                r.num  = x * tgt + {16'd0, src >> 1};
                r.den  = src;
                r.mode = (r.num[31:16] >= src) ? MODE_SAT : MODE_SCALE;
            end
        end
        return r;
    endfunction

    // (x*255 + 32767) / 65535
    function automatic logic [7:0] to_chan(input logic [15:0] x);
        logic [31:0] p;
        logic [15:0] q;
        p = ({16'd0, x} << 8) - {16'd0, x} + {16'd0, HALF};
        q = div65535(p);
        return q[7:0];
    endfunction

endpackage

// ===== sv/relative_hsv_colour_map.sv =====
// Relative HSV colour map: pipelined RGB->HSV, hue/sat/val remap, HSV->RGB.
//
// Usage:
//   Pixel in: drive red_in/green_in/blue_in/alpha_in and pulse start. busy is
//   always low, so a word is taken at every edge where start is high; a new
//   pixel may enter in every cycle.
//   Result: red_out..alpha_out are valid for one cycle while done is high.
//   Throughput is one pixel per cycle.
//   The latency is set by two 16-step restoring dividers in series (RGB->HSV
//   divide, then the sat/val remap divide), plus eight arithmetic stages.
//   Configuration: wr_en/wr_index/wr_data write one of the six 16-bit
//   registers at once; indexes past the last register are ignored. Write
//   only while no pixel is in flight.
//   Reset: registers return to their defaults and all in-flight pixels are
//   dropped. The receiver cannot stall; results must be taken when done is high.
module relative_hsv_colour_map
    import rhcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic [7:0]  alpha_in,
    output logic        done,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic [7:0]  alpha_out,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [15:0] wr_data
);

    logic [15:0] src_hue_reg, src_sat_reg, src_val_reg;
    logic [15:0] tgt_hue_reg, tgt_sat_reg, tgt_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_hue_reg <= 16'd7864;
            src_sat_reg <= 16'd47186;
            src_val_reg <= 16'd32768;
            tgt_hue_reg <= 16'd15729;
            tgt_sat_reg <= 16'd19661;
            tgt_val_reg <= 16'd52429;
        end
        else if (wr_en)
        begin
            case (cfg_index_t'(wr_index))
                REG_SOURCE_HUE: src_hue_reg <= wr_data;
                REG_SOURCE_SAT: src_sat_reg <= wr_data;
                REG_SOURCE_VAL: src_val_reg <= wr_data;
                REG_TARGET_HUE: tgt_hue_reg <= wr_data;
                REG_TARGET_SAT: tgt_sat_reg <= wr_data;
                REG_TARGET_VAL: tgt_val_reg <= wr_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // ---------------- stage 1: max/min, hue numerator, divider setup
    logic [7:0]  mx, mn, delta;
    logic [10:0] num;
    logic [31:0] s_acc_next, h_acc_next;
    logic [15:0] s_den_next, h_den_next;
    logic [10:0] six_d;

    always_comb
    begin
        mx = (red_in > green_in) ? red_in : green_in;
        if (blue_in > mx) mx = blue_in;
        mn = (red_in < green_in) ? red_in : green_in;
        if (blue_in < mn) mn = blue_in;
        delta = mx - mn;
        six_d = 11'd6 * {3'd0, delta};
        if (red_in == mx)
            num = (green_in >= blue_in) ? {3'd0, green_in - blue_in}
                                        : six_d - {3'd0, blue_in - green_in};
        else if (green_in == mx)
            num = (blue_in >= red_in) ? {2'd0, delta, 1'b0} + {3'd0, blue_in - red_in}
                                      : {2'd0, delta, 1'b0} - {3'd0, red_in - blue_in};
        else
            num = (red_in >= green_in) ? {1'b0, delta, 2'd0} + {3'd0, red_in - green_in}
                                       : {1'b0, delta, 2'd0} - {3'd0, green_in - red_in};
        h_acc_next = {5'd0, num, 16'd0} + 32'd3 * {24'd0, delta};
        h_den_next = {5'd0, six_d};
        s_acc_next = {8'd0, delta, 16'd0} - {24'd0, delta} + {25'd0, mx[7:1]};
        s_den_next = {8'd0, mx};
    end

    // ---------------- first divider: saturation and hue
    logic [31:0] d1s_acc_reg [0:DIV_STEPS];
    logic [15:0] d1s_den_reg [0:DIV_STEPS];
    logic [31:0] d1h_acc_reg [0:DIV_STEPS];
    logic [15:0] d1h_den_reg [0:DIV_STEPS];
    logic [15:0] d1v_reg     [0:DIV_STEPS];
    logic        d1z_reg     [0:DIV_STEPS];
    logic [7:0]  d1a_reg     [0:DIV_STEPS];
    logic        d1vld_reg   [0:DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STEPS; k++)
                d1vld_reg[k] <= 1'b0;
        end
        else
        begin
            d1vld_reg[0] <= start;
            for (int k = 0; k < DIV_STEPS; k++)
                d1vld_reg[k+1] <= d1vld_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        d1s_acc_reg[0] <= s_acc_next;
        d1s_den_reg[0] <= s_den_next;
        d1h_acc_reg[0] <= h_acc_next;
        d1h_den_reg[0] <= h_den_next;
        d1v_reg[0]     <= {mx, mx};
        d1z_reg[0]     <= (delta == 8'd0);
        d1a_reg[0]     <= alpha_in;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            d1s_acc_reg[k+1] <= div_step(d1s_acc_reg[k], d1s_den_reg[k]);
            d1s_den_reg[k+1] <= d1s_den_reg[k];
            d1h_acc_reg[k+1] <= div_step(d1h_acc_reg[k], d1h_den_reg[k]);
            d1h_den_reg[k+1] <= d1h_den_reg[k];
            d1v_reg[k+1]     <= d1v_reg[k];
            d1z_reg[k+1]     <= d1z_reg[k];
            d1a_reg[k+1]     <= d1a_reg[k];
        end
    end

    // ---------------- stage 2: hue rotate, remap setup
    logic [15:0] s_hsv, h_hsv, hue_next;
    remap_t      rs_next, rv_next;

    always_comb
    begin
        s_hsv    = d1z_reg[DIV_STEPS] ? 16'd0 : d1s_acc_reg[DIV_STEPS][15:0];
        h_hsv    = d1z_reg[DIV_STEPS] ? 16'd0 : d1h_acc_reg[DIV_STEPS][15:0];
        hue_next = h_hsv + tgt_hue_reg - src_hue_reg;
        rs_next  = remap_setup(s_hsv, src_sat_reg, tgt_sat_reg);
        rv_next  = remap_setup(d1v_reg[DIV_STEPS], src_val_reg, tgt_val_reg);
    end

    // ---------------- second divider: saturation and value remap
    logic [31:0] d2s_acc_reg [0:DIV_STEPS];
    logic [31:0] d2v_acc_reg [0:DIV_STEPS];
    remap_t      d2s_reg     [0:DIV_STEPS];
    remap_t      d2v_reg     [0:DIV_STEPS];
    logic [15:0] d2h_reg     [0:DIV_STEPS];
    logic [7:0]  d2a_reg     [0:DIV_STEPS];
    logic        d2vld_reg   [0:DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STEPS; k++)
                d2vld_reg[k] <= 1'b0;
        end
        else
        begin
            d2vld_reg[0] <= d1vld_reg[DIV_STEPS];
            for (int k = 0; k < DIV_STEPS; k++)
                d2vld_reg[k+1] <= d2vld_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        d2s_acc_reg[0] <= rs_next.num;
        d2v_acc_reg[0] <= rv_next.num;
        d2s_reg[0]     <= rs_next;
        d2v_reg[0]     <= rv_next;
        d2h_reg[0]     <= hue_next;
        d2a_reg[0]     <= d1a_reg[DIV_STEPS];
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            d2s_acc_reg[k+1] <= div_step(d2s_acc_reg[k], d2s_reg[k].den);
            d2v_acc_reg[k+1] <= div_step(d2v_acc_reg[k], d2v_reg[k].den);
            d2s_reg[k+1]     <= d2s_reg[k];
            d2v_reg[k+1]     <= d2v_reg[k];
            d2h_reg[k+1]     <= d2h_reg[k];
            d2a_reg[k+1]     <= d2a_reg[k];
        end
    end

    function automatic logic [15:0] remap_finish(input remap_t r, input logic [15:0] q);
        logic [15:0] res;
        case (r.mode)
            MODE_PASS:  res = r.x;
            MODE_HEAD:  res = ONE - q;
            MODE_SAT:   res = ONE;
            MODE_SCALE: res = q;
            default:    res = q;
        endcase
        return res;
    endfunction

    // ---------------- stage 3: final sat/val, hue sector
    logic [18:0] h6;
    logic [15:0] p3_s_reg, p3_v_reg, p3_f_reg;
    logic [2:0]  p3_sec_reg;
    logic [7:0]  p3_a_reg;
    logic        p3_vld_reg;

    assign h6 = {3'd0, d2h_reg[DIV_STEPS]} * 19'd6;

    always_ff @(posedge clk)
    begin
        p3_s_reg   <= remap_finish(d2s_reg[DIV_STEPS], d2s_acc_reg[DIV_STEPS][15:0]);
        p3_v_reg   <= remap_finish(d2v_reg[DIV_STEPS], d2v_acc_reg[DIV_STEPS][15:0]);
        p3_f_reg   <= h6[15:0];
        p3_sec_reg <= h6[18:16];
        p3_a_reg   <= d2a_reg[DIV_STEPS];
    end

    // ---------------- stage 4: sf, sg
    logic [32:0] sf_prod, sg_prod;
    logic [16:0] f_comp;
    logic [15:0] p4_s_reg, p4_v_reg, p4_sf_reg, p4_sg_reg;
    logic [2:0]  p4_sec_reg;
    logic [7:0]  p4_a_reg;
    logic        p4_vld_reg;

    assign f_comp  = 17'h10000 - {1'b0, p3_f_reg};
    assign sf_prod = {17'd0, p3_s_reg} * {17'd0, p3_f_reg} + 33'h8000;
    assign sg_prod = {17'd0, p3_s_reg} * {16'd0, f_comp} + 33'h8000;

    always_ff @(posedge clk)
    begin
        p4_s_reg   <= p3_s_reg;
        p4_v_reg   <= p3_v_reg;
        p4_sf_reg  <= sf_prod[31:16];
        p4_sg_reg  <= sg_prod[31:16];
        p4_sec_reg <= p3_sec_reg;
        p4_a_reg   <= p3_a_reg;
    end

    // ---------------- stage 5: v*(1-x) products
    logic [31:0] p5_w_reg, p5_q_reg, p5_t_reg;
    logic [15:0] p5_v_reg;
    logic [2:0]  p5_sec_reg;
    logic [7:0]  p5_a_reg;
    logic        p5_vld_reg;

    always_ff @(posedge clk)
    begin
        p5_w_reg   <= p4_v_reg * (ONE - p4_s_reg) + {16'd0, HALF};
        p5_q_reg   <= p4_v_reg * (ONE - p4_sf_reg) + {16'd0, HALF};
        p5_t_reg   <= p4_v_reg * (ONE - p4_sg_reg) + {16'd0, HALF};
        p5_v_reg   <= p4_v_reg;
        p5_sec_reg <= p4_sec_reg;
        p5_a_reg   <= p4_a_reg;
    end

    // ---------------- stage 6: divide by ONE (65535)
    logic [15:0] p6_w_reg, p6_q_reg, p6_t_reg, p6_v_reg;
    logic [2:0]  p6_sec_reg;
    logic [7:0]  p6_a_reg;
    logic        p6_vld_reg;

    always_ff @(posedge clk)
    begin
        p6_w_reg   <= div65535(p5_w_reg);
        p6_q_reg   <= div65535(p5_q_reg);
        p6_t_reg   <= div65535(p5_t_reg);
        p6_v_reg   <= p5_v_reg;
        p6_sec_reg <= p5_sec_reg;
        p6_a_reg   <= p5_a_reg;
    end

    // ---------------- stage 7: to channel depth
    logic [7:0] p7_w_reg, p7_q_reg, p7_t_reg, p7_v_reg;
    logic [2:0] p7_sec_reg;
    logic [7:0] p7_a_reg;
    logic       p7_vld_reg;

    always_ff @(posedge clk)
    begin
        p7_w_reg   <= to_chan(p6_w_reg);
        p7_q_reg   <= to_chan(p6_q_reg);
        p7_t_reg   <= to_chan(p6_t_reg);
        p7_v_reg   <= to_chan(p6_v_reg);
        p7_sec_reg <= p6_sec_reg;
        p7_a_reg   <= p6_a_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p3_vld_reg <= 1'b0;
            p4_vld_reg <= 1'b0;
            p5_vld_reg <= 1'b0;
            p6_vld_reg <= 1'b0;
            p7_vld_reg <= 1'b0;
            done       <= 1'b0;
        end
        else
        begin
            p3_vld_reg <= d2vld_reg[DIV_STEPS];
            p4_vld_reg <= p3_vld_reg;
            p5_vld_reg <= p4_vld_reg;
            p6_vld_reg <= p5_vld_reg;
            p7_vld_reg <= p6_vld_reg;
            done       <= p7_vld_reg;
        end
    end

    // ---------------- stage 8: sector select, output word
    always_ff @(posedge clk)
    begin
        alpha_out <= p7_a_reg;
        case (p7_sec_reg)
            3'd0:
            begin
                red_out <= p7_v_reg; green_out <= p7_t_reg; blue_out <= p7_w_reg;
            end
            3'd1:
            begin
                red_out <= p7_q_reg; green_out <= p7_v_reg; blue_out <= p7_w_reg;
            end
            3'd2:
            begin
                red_out <= p7_w_reg; green_out <= p7_v_reg; blue_out <= p7_t_reg;
            end
            3'd3:
            begin
                red_out <= p7_w_reg; green_out <= p7_q_reg; blue_out <= p7_v_reg;
            end
            3'd4:
            begin
                red_out <= p7_t_reg; green_out <= p7_w_reg; blue_out <= p7_v_reg;
            end
            default:
            begin
                red_out <= p7_v_reg; green_out <= p7_w_reg; blue_out <= p7_q_reg;
            end
        endcase
    end

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the relative HSV colour map block.
`timescale 1ns / 1ps

module tb;
    import rhcm_pkg::*;

    localparam int LATENCY = 39;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [7:0]  alpha_in;
    logic        done;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [7:0]  alpha_out;
    logic        wr_en;
    logic [2:0]  wr_index;
    logic [15:0] wr_data;

    // shadow copy of the six registers
    logic [15:0] regs [6];

    pixel_t      mapped_q [$];
    int          errors;
    int          send_idle_pct;

    relative_hsv_colour_map uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .alpha_in  (alpha_in),
        .done      (done),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .alpha_out (alpha_out),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic longint unsigned scale_sv(longint unsigned x, longint unsigned src,
                                                 longint unsigned tgt);
        longint unsigned r;
        if (src == 0)
            return x;
        if (tgt > src && x > src)
            return 65535 - ((65535 - x) * (65535 - tgt) + (65535 - src) / 2) / (65535 - src);
        r = (x * tgt + src / 2) / src;
        return (r > 65535) ? 65535 : r;
    endfunction

    function automatic longint unsigned chan_of(longint unsigned x);
        return (x * 255 + 32767) / 65535;
    endfunction

    function automatic pixel_t map_pixel(pixel_t p);
        longint unsigned r, g, b, mx, mn, dl, h, s, v, num;
        longint unsigned h6, sec, f, sf, sg, w, q, t, vc, wc, qc, tc;
        pixel_t o;
        r = p.red;
        g = p.green;
        b = p.blue;
        mx = (r > g) ? r : g;
        if (b > mx) mx = b;
        mn = (r < g) ? r : g;
        if (b < mn) mn = b;
        dl = mx - mn;
        v = (mx * 65535 + 127) / 255;
        s = (mx != 0) ? (dl * 65535 + mx / 2) / mx : 0;
        if (dl == 0)
            h = 0;
        else
        begin
            if (r == mx)
                num = (g >= b) ? (g - b) : (6 * dl - (b - g));
            else if (g == mx)
                num = (b >= r) ? (2 * dl + (b - r)) : (2 * dl - (r - b));
            else
                num = (r >= g) ? (4 * dl + (r - g)) : (4 * dl - (g - r));
            h = (((num << 16) + 3 * dl) / (6 * dl)) & 65535;
        end
        h = (h + regs[REG_TARGET_HUE] + 65536 - regs[REG_SOURCE_HUE]) & 65535;
        s = scale_sv(s, regs[REG_SOURCE_SAT], regs[REG_TARGET_SAT]);
        v = scale_sv(v, regs[REG_SOURCE_VAL], regs[REG_TARGET_VAL]);
        h6 = h * 6;
        sec = h6 >> 16;
        f = h6 & 65535;
        sf = (s * f + 32768) >> 16;
        sg = (s * (65536 - f) + 32768) >> 16;
        w = (v * (65535 - s) + 32767) / 65535;
        q = (v * (65535 - sf) + 32767) / 65535;
        t = (v * (65535 - sg) + 32767) / 65535;
        vc = chan_of(v);
        wc = chan_of(w);
        qc = chan_of(q);
        tc = chan_of(t);
        case (sec)
            0: begin o.red = vc; o.green = tc; o.blue = wc; end
            1: begin o.red = qc; o.green = vc; o.blue = wc; end
            2: begin o.red = wc; o.green = vc; o.blue = tc; end
            3: begin o.red = wc; o.green = qc; o.blue = vc; end
            4: begin o.red = tc; o.green = wc; o.blue = vc; end
            default: begin o.red = vc; o.green = wc; o.blue = qc; end
        endcase
        o.alpha = p.alpha;
        return o;
    endfunction

    // start stays high after the last word; drain() drops it
    task automatic send_pixel(pixel_t p);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start    <= 1'b1;
        red_in   <= p.red;
        green_in <= p.green;
        blue_in  <= p.blue;
        alpha_in <= p.alpha;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        mapped_q.push_back(map_pixel(p));
        @(negedge clk);
    endtask

    task automatic send_rgba(int r, int g, int b, int a);
        pixel_t p;
        p.red = r;
        p.green = g;
        p.blue = b;
        p.alpha = a;
        send_pixel(p);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (mapped_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // block must be idle here
    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(negedge clk);
        wr_en    <= 1'b0;
        if (idx < 6)
            regs[idx] = val;
        @(negedge clk);
    endtask

    task automatic load_regs(logic [15:0] sh, logic [15:0] ss, logic [15:0] sv,
                             logic [15:0] th, logic [15:0] ts, logic [15:0] tv);
        write_reg(REG_SOURCE_HUE, sh);
        write_reg(REG_SOURCE_SAT, ss);
        write_reg(REG_SOURCE_VAL, sv);
        write_reg(REG_TARGET_HUE, th);
        write_reg(REG_TARGET_SAT, ts);
        write_reg(REG_TARGET_VAL, tv);
    endtask

    task automatic send_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                int g;
                g = $urandom_range(255);
                send_rgba(g, g, g, $urandom_range(255));
            end
            else
                send_rgba($urandom_range(255), $urandom_range(255), $urandom_range(255),
                          $urandom_range(255));
        end
    endtask

    task automatic test_directed();
        send_rgba(0, 0, 0, 0);
        send_rgba(255, 255, 255, 255);
        send_rgba(128, 128, 128, 85);
        send_rgba(255, 0, 0, 170);
        send_rgba(0, 255, 0, 1);
        send_rgba(0, 0, 255, 254);
        send_rgba(255, 255, 0, 128);
        send_rgba(0, 255, 255, 127);
        send_rgba(255, 0, 255, 64);
        send_rgba(255, 1, 0, 2);
        send_rgba(0, 1, 255, 3);
        send_rgba(1, 0, 0, 200);
        send_rgba(200, 10, 90, 33);
        send_rgba(30, 240, 200, 99);
        drain();
    endtask

    task automatic test_register_settings();
        // zero source sat/val: pass-through of both
        load_regs(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_random(40);
        drain();
        // full source, zero targets
        load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        send_random(40);
        drain();
        // headroom scaling with small sources, large targets
        load_regs(16'h1234, 16'h0001, 16'h0001, 16'h8000, 16'hFFFE, 16'hFFFF);
        send_random(40);
        drain();
        // saturation scaled down to zero, value scaled up from half to full
        load_regs(16'h0000, 16'hFFFF, 16'h8000, 16'h0000, 16'h0000, 16'hFFFF);
        send_random(40);
        drain();
        write_reg(3'd6, 16'hAAAA);
        write_reg(3'd7, 16'h5555);
        send_random(10);
        drain();
    endtask

    task automatic test_random_phase(int pct, int n);
        send_idle_pct = pct;
        for (int k = 0; k < 4; k++)
        begin
            load_regs($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                      $urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
            send_random(n / 4);
            drain();
        end
    endtask

    always @(posedge clk)
    begin
        pixel_t e;
        if (rst_n && done)
        begin
            if (mapped_q.size() == 0)
            begin
                $display("%0t: result with no pixel pending: %h %h %h %h", $time,
                         red_out, green_out, blue_out, alpha_out);
                errors++;
            end
            else
            begin
                e = mapped_q.pop_front();
                if (red_out !== e.red || green_out !== e.green || blue_out !== e.blue ||
                    alpha_out !== e.alpha)
                begin
                    $display("%0t: mismatch exp rgba %h %h %h %h got %h %h %h %h", $time,
                             e.red, e.green, e.blue, e.alpha,
                             red_out, green_out, blue_out, alpha_out);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        errors        = 0;
        send_idle_pct = 0;
        rst_n         = 1'b0;
        start         = 1'b0;
        red_in        = '0;
        green_in      = '0;
        blue_in       = '0;
        alpha_in      = '0;
        wr_en         = 1'b0;
        wr_index      = '0;
        wr_data       = '0;
        regs[0] = 16'd7864;
        regs[1] = 16'd47186;
        regs[2] = 16'd32768;
        regs[3] = 16'd15729;
        regs[4] = 16'd19661;
        regs[5] = 16'd52429;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_register_settings();
        test_random_phase(15, 256);
        test_random_phase(60, 256);
        test_random_phase(0, 256);
        drain();

        if (errors == 0 && mapped_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
sv/rhcm_pkg.sv
sv/relative_hsv_colour_map.sv
dv/tb.sv
